### src/rcsd_pkg.sv
// Shared types, constants and the SSRC match function for the RTCP compound
// packet SSRC demultiplexer. No dependencies.
`default_nettype none

package rcsd_pkg;

  localparam int NUM_SINKS = 4;
  localparam int REG_COUNT = 5;
  localparam int ADDR_W    = 5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SSRC_A = 3'd0;
  localparam logic [2:0] REG_SSRC_B = 3'd1;
  localparam logic [2:0] REG_SSRC_C = 3'd2;
  localparam logic [2:0] REG_SSRC_D = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;

  // RTCP packet types
  localparam logic [7:0] PT_SR    = 8'd200;
  localparam logic [7:0] PT_RR    = 8'd201;
  localparam logic [7:0] PT_BYE   = 8'd203;
  localparam logic [7:0] PT_RTPFB = 8'd205;
  localparam logic [7:0] PT_PSFB  = 8'd206;

  localparam logic [2:0] SR_FIRST_BLOCK = 3'd6;
  localparam logic [2:0] RR_FIRST_BLOCK = 3'd1;
  localparam logic [2:0] BLOCK_GAP      = 3'd5;

  localparam logic [3:0] SLOT_MASK = 4'((1 << NUM_SINKS) - 1);

  typedef struct packed {
    logic [3:0][31:0] ssrc;
    logic [3:0]       enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        full;
  } word_t;

  function automatic logic [3:0] match_ssrc(cfg_t cfg, logic [31:0] w);
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < NUM_SINKS; i++) begin
      if (cfg.ssrc[i] == w) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### src/rcsd_cfg_regs.sv
// APB-style register file holding the four sink SSRCs and the enable bits.
// Depends on rcsd_pkg.
`default_nettype none

module rcsd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rcsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output rcsd_pkg::cfg_t                  cfg
);

  logic [2:0] reg_index;
  logic       wr;

  assign reg_index = paddr[rcsd_pkg::ADDR_W-1:2];
  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (reg_index)
        rcsd_pkg::REG_SSRC_A: cfg.ssrc[0] <= pwdata;
        rcsd_pkg::REG_SSRC_B: cfg.ssrc[1] <= pwdata;
        rcsd_pkg::REG_SSRC_C: cfg.ssrc[2] <= pwdata;
        rcsd_pkg::REG_SSRC_D: cfg.ssrc[3] <= pwdata;
        rcsd_pkg::REG_ENABLE: cfg.enable  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rcsd_pkg::REG_SSRC_A: prdata = cfg.ssrc[0];
      rcsd_pkg::REG_SSRC_B: prdata = cfg.ssrc[1];
      rcsd_pkg::REG_SSRC_C: prdata = cfg.ssrc[2];
      rcsd_pkg::REG_SSRC_D: prdata = cfg.ssrc[3];
      rcsd_pkg::REG_ENABLE: prdata = {28'd0, cfg.enable};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/rcsd_in_stage.sv
// Input register for packet words; holds one request until the parser takes it.
// Depends on rcsd_pkg.
`default_nettype none

module rcsd_in_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] packet_word,
  input  wire logic        last_word,
  input  wire logic [2:0]  last_word_bytes,
  input  wire logic        take,
  output logic             item_valid,
  output rcsd_pkg::word_t  item
);

  logic load;

  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
    if (load) begin
      item.word <= packet_word;
      item.last <= last_word;
      // a short final word is dropped
      item.full <= !last_word || (last_word_bytes >= 3'd4);
    end
  end

endmodule

`default_nettype wire

### src/rcsd_parser.sv
// Sub-packet walker, SSRC matching and the result register.
// Depends on rcsd_pkg.
`default_nettype none

module rcsd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rcsd_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire rcsd_pkg::word_t item,
  output logic                 take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 accepted,
  output logic [3:0]           deliver_mask,
  output logic                 deliver_everyone
);

  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_SR,
    KIND_RR,
    KIND_FB,
    KIND_BYE
  } kind_t;

  logic        rtcp_valid, rtcp_valid_next;
  logic        at_start, at_start_next;
  logic        stopped, stopped_next;
  logic        everyone, everyone_next;
  logic        pend_every, pend_every_next;
  logic [3:0]  committed, committed_next;
  logic [3:0]  pending, pending_next;
  logic [15:0] words_left, words_left_next;
  logic [1:0]  pos, pos_next;
  logic [2:0]  gap, gap_next;
  logic [4:0]  blk_idx, blk_idx_next;
  logic [4:0]  block_count, block_count_next;
  kind_t       kind, kind_next;

  logic [3:0]  m;
  logic [6:0]  pt7;
  logic        fin;
  logic        blk_hit;
  logic [3:0]  en;
  logic        acc;
  logic [31:0] w;

  // a non-final word produces no result, so it never waits on the output
  assign take = item_valid && (!item.last || !out_valid || !out_stall);
  assign w    = item.word;
  assign m    = rcsd_pkg::match_ssrc(cfg, w);
  assign pt7  = w[22:16];

  always_comb begin
    rtcp_valid_next  = rtcp_valid;
    at_start_next    = at_start;
    stopped_next     = stopped;
    everyone_next    = everyone;
    pend_every_next  = pend_every;
    committed_next   = committed;
    pending_next     = pending;
    words_left_next  = words_left;
    pos_next         = pos;
    gap_next         = gap;
    blk_idx_next     = blk_idx;
    block_count_next = block_count;
    kind_next        = kind;
    fin              = 1'b0;
    blk_hit          = (gap == 3'd0) && (blk_idx < block_count);

    if (item.full) begin
      if (at_start) begin
        rtcp_valid_next = (w[31:30] == 2'd2) && (pt7 inside {[7'd64:7'd95]});
        at_start_next   = 1'b0;
      end
      if (!stopped) begin
        if (words_left == 16'd0) begin
          // sub-packet header
          block_count_next = w[28:24];
          pending_next     = '0;
          pend_every_next  = 1'b0;
          pos_next         = 2'd0;
          blk_idx_next     = 5'd0;
          gap_next         = 3'd0;
          case (w[23:16])
            rcsd_pkg::PT_SR: begin
              kind_next = KIND_SR;
              gap_next  = rcsd_pkg::SR_FIRST_BLOCK;
            end
            rcsd_pkg::PT_RR: begin
              kind_next = KIND_RR;
              gap_next  = rcsd_pkg::RR_FIRST_BLOCK;
            end
            rcsd_pkg::PT_RTPFB, rcsd_pkg::PT_PSFB: kind_next = KIND_FB;
            rcsd_pkg::PT_BYE: kind_next = KIND_BYE;
            default: begin
              kind_next       = KIND_SKIP;
              pend_every_next = 1'b1;
            end
          endcase
          words_left_next = w[15:0];
          fin             = (w[15:0] == 16'd0);
        end else begin
          case (kind)
            KIND_SR: begin
              if (pos == 2'd0 || blk_hit) pending_next = pending | m;
            end
            KIND_RR: begin
              if (blk_hit) pending_next = pending | m;
            end
            KIND_FB: begin
              if (pos == 2'd0) begin
                pending_next = pending | m;
              end else if (pos == 2'd1) begin
                if (w != 32'd0) pending_next = pending | m;
                else            pend_every_next = 1'b1;
              end
            end
            KIND_BYE: begin
              if (pos == 2'd0 && w != 32'd0) pending_next = pending | m;
            end
            default: ;
          endcase
          if (pos != 2'd2) pos_next = pos + 2'd1;
          // advance the report-block stride
          if (gap == 3'd0) begin
            gap_next = rcsd_pkg::BLOCK_GAP;
            if (blk_idx != 5'd31) blk_idx_next = blk_idx + 5'd1;
          end else begin
            gap_next = gap - 3'd1;
          end
          words_left_next = words_left - 16'd1;
          fin             = (words_left == 16'd1);
        end
        if (fin) begin
          committed_next = committed | pending_next;
          if (pend_every_next) begin
            everyone_next = 1'b1;
            stopped_next  = 1'b1;
          end
          pending_next    = '0;
          pend_every_next = 1'b0;
          kind_next       = KIND_SKIP;
          pos_next        = 2'd0;
        end
      end
    end

    en  = cfg.enable & rcsd_pkg::SLOT_MASK;
    acc = rtcp_valid_next && !at_start_next && (en != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      rtcp_valid  <= 1'b0;
      at_start    <= 1'b1;
      stopped     <= 1'b0;
      everyone    <= 1'b0;
      pend_every  <= 1'b0;
      committed   <= '0;
      pending     <= '0;
      words_left  <= '0;
      pos         <= '0;
      gap         <= '0;
      blk_idx     <= '0;
      block_count <= '0;
      kind        <= KIND_SKIP;
    end else if (take) begin
      rtcp_valid  <= rtcp_valid_next;
      at_start    <= at_start_next;
      stopped     <= stopped_next;
      everyone    <= everyone_next;
      pend_every  <= pend_every_next;
      committed   <= committed_next;
      pending     <= pending_next;
      words_left  <= words_left_next;
      pos         <= pos_next;
      gap         <= gap_next;
      blk_idx     <= blk_idx_next;
      block_count <= block_count_next;
      kind        <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (take && item.last) begin
      accepted         <= acc;
      deliver_everyone <= acc && everyone_next;
      if (!acc)               deliver_mask <= '0;
      else if (everyone_next) deliver_mask <= en;
      else                    deliver_mask <= committed_next & en;
    end
  end

endmodule

`default_nettype wire

### src/rtcp_compound_ssrc_demux_unit.sv
// Top level of the RTCP compound packet SSRC demultiplexer.
// Depends on rcsd_pkg, rcsd_cfg_regs, rcsd_in_stage and rcsd_parser.
//
// Takes one 32-bit packet word per cycle, sustained while the output is
// not stalled, with no gaps needed between packets. Each word is registered,
// then parsed against the sink SSRC registers in the following cycle; the
// result for a packet is registered once its last word is taken. Stalling
// the output only holds back a last word; the words before it keep flowing.
// The sink SSRC and enable registers should be written between packets.
`default_nettype none

module rtcp_compound_ssrc_demux_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [31:0]                 packet_word,
  input  wire logic                        last_word,
  input  wire logic [2:0]                  last_word_bytes,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             accepted,
  output logic [3:0]                       deliver_mask,
  output logic                             deliver_everyone
);

  rcsd_pkg::cfg_t  cfg;
  rcsd_pkg::word_t item;
  logic            item_valid;
  logic            take;

  rcsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcsd_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .packet_word     (packet_word),
    .last_word       (last_word),
    .last_word_bytes (last_word_bytes),
    .take            (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  rcsd_parser u_parse (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .item_valid       (item_valid),
    .item             (item),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .accepted         (accepted),
    .deliver_mask     (deliver_mask),
    .deliver_everyone (deliver_everyone)
  );

endmodule

`default_nettype wire

### src/rcsd_checker.sv
// Port-level checks for the demultiplexer top level, bound to it below.
// Depends on rtcp_compound_ssrc_demux_unit.
`default_nettype none

module rcsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       accepted,
  input wire logic [3:0] deliver_mask,
  input wire logic       deliver_everyone
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable(accepted) && $stable(deliver_mask) && $stable(deliver_everyone))
    else $error("stalled result changed");

  // a rejected packet goes nowhere
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> deliver_mask == 4'd0 && !deliver_everyone)
    else $error("rejected packet has delivery");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // reset empties both sides
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind rtcp_compound_ssrc_demux_unit rcsd_checker u_rcsd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .accepted         (accepted),
  .deliver_mask     (deliver_mask),
  .deliver_everyone (deliver_everyone)
);

`default_nettype wire

### test/rcsd_demux_checker.sv
// Checker for the RTCP compound packet SSRC demultiplexer: follows the config
// port and the packet input, predicts each packet's delivery and compares it.
// Depends on rcsd_pkg for widths, register indexes and packet type codes.
`timescale 1ns / 1ps

module rcsd_demux_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [rcsd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [31:0]                 packet_word,
  input  logic                        last_word,
  input  logic [2:0]                  last_word_bytes,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        accepted,
  input  logic [3:0]                  deliver_mask,
  input  logic                        deliver_everyone,
  output int                          mismatches,
  output int                          awaiting
);

  typedef enum logic [2:0] {SUB_SKIP, SUB_SR, SUB_RR, SUB_FB, SUB_BYE} sub_kind_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] mask;
    logic       everyone;
  } delivery_t;

  logic [31:0] reg_ssrc [rcsd_pkg::NUM_SINKS];
  logic [3:0]  reg_enable;

  logic [3:0]  kept_mask;
  logic [3:0]  sub_mask;
  logic        sub_flood;
  logic        flood;
  logic        halted;
  logic        is_rtcp;
  logic        fresh;
  logic [16:0] words_due;
  logic [16:0] offset;
  sub_kind_t   kind;
  logic [4:0]  blocks;

  delivery_t   due_deliveries[$];
  int          errs;

  function automatic logic [3:0] ssrc_hits(input logic [31:0] w);
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < rcsd_pkg::NUM_SINKS; i++) begin
      if (reg_ssrc[i] == w) m[i] = 1'b1;
    end
    return m;
  endfunction

  task automatic restart_packet();
    kept_mask = '0;
    sub_mask  = '0;
    sub_flood = 1'b0;
    flood     = 1'b0;
    halted    = 1'b0;
    is_rtcp   = 1'b0;
    fresh     = 1'b1;
    words_due = '0;
    offset    = '0;
    kind      = SUB_SKIP;
    blocks    = '0;
  endtask

  // commit what the sub-packet collected once its last word is in
  task automatic close_sub();
    kept_mask = kept_mask | sub_mask;
    if (sub_flood) begin
      flood  = 1'b1;
      halted = 1'b1;
    end
    sub_mask  = '0;
    sub_flood = 1'b0;
    kind      = SUB_SKIP;
    offset    = '0;
  endtask

  task automatic route_word(input logic [31:0] w, input logic last, input logic [2:0] nbytes);
    int        p;
    logic [3:0] en;
    delivery_t d;
    p = int'(offset);
    // a short final word is dropped
    if (!last || nbytes >= 3'd4) begin
      if (fresh) begin
        is_rtcp = (w[31:30] == 2'd2) && (w[22:16] >= 7'd64) && (w[22:16] <= 7'd95);
        fresh   = 1'b0;
      end
      if (!halted) begin
        if (words_due == 0) begin
          blocks    = w[28:24];
          sub_mask  = '0;
          sub_flood = 1'b0;
          offset    = '0;
          case (w[23:16])
            rcsd_pkg::PT_SR:    kind = SUB_SR;
            rcsd_pkg::PT_RR:    kind = SUB_RR;
            rcsd_pkg::PT_RTPFB,
            rcsd_pkg::PT_PSFB:  kind = SUB_FB;
            rcsd_pkg::PT_BYE:   kind = SUB_BYE;
            default: begin
              kind      = SUB_SKIP;
              sub_flood = 1'b1;
            end
          endcase
          words_due = {1'b0, w[15:0]};
          if (words_due == 0) close_sub();
        end else begin
          case (kind)
            SUB_SR: begin
              if (p == 0 || (p >= 6 && (p - 6) % 6 == 0 && (p - 6) / 6 < int'(blocks)))
                sub_mask |= ssrc_hits(w);
            end
            SUB_RR: begin
              if (p >= 1 && (p - 1) % 6 == 0 && (p - 1) / 6 < int'(blocks))
                sub_mask |= ssrc_hits(w);
            end
            SUB_FB: begin
              if (p == 0 || (p == 1 && w != 0)) sub_mask |= ssrc_hits(w);
              else if (p == 1) sub_flood = 1'b1;
            end
            SUB_BYE: begin
              if (p == 0 && w != 0) sub_mask |= ssrc_hits(w);
            end
            default: ;
          endcase
          if (offset != 17'h1FFFF) offset++;
          words_due--;
          if (words_due == 0) close_sub();
        end
      end
    end
    if (last) begin
      en = reg_enable & rcsd_pkg::SLOT_MASK;
      d  = '0;
      d.accepted = is_rtcp && !fresh && (en != 0);
      if (d.accepted) begin
        d.everyone = flood;
        d.mask     = flood ? en : (kept_mask & en);
      end
      due_deliveries.push_back(d);
      restart_packet();
    end
  endtask

  always @(posedge clk) begin
    delivery_t d;
    if (rst) begin
      for (int i = 0; i < rcsd_pkg::NUM_SINKS; i++) reg_ssrc[i] = '0;
      reg_enable = '0;
      restart_packet();
      due_deliveries.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[rcsd_pkg::ADDR_W-1:2])
          rcsd_pkg::REG_SSRC_A: reg_ssrc[0] = pwdata;
          rcsd_pkg::REG_SSRC_B: reg_ssrc[1] = pwdata;
          rcsd_pkg::REG_SSRC_C: reg_ssrc[2] = pwdata;
          rcsd_pkg::REG_SSRC_D: reg_ssrc[3] = pwdata;
          rcsd_pkg::REG_ENABLE: reg_enable  = pwdata[3:0];
          default: ;
        endcase
      end
      // compare before predicting so a result never meets its own packet
      if (out_valid && !out_stall) begin
        if (due_deliveries.size() == 0) begin
          $error("delivery with no packet outstanding: accepted %0d mask %h everyone %0d",
                 accepted, deliver_mask, deliver_everyone);
          errs++;
        end else begin
          d = due_deliveries.pop_front();
          if (accepted !== d.accepted) begin
            $error("accepted: expected %0d, got %0d", d.accepted, accepted);
            errs++;
          end
          if (deliver_mask !== d.mask) begin
            $error("deliver_mask: expected %h, got %h", d.mask, deliver_mask);
            errs++;
          end
          if (deliver_everyone !== d.everyone) begin
            $error("deliver_everyone: expected %0d, got %0d", d.everyone, deliver_everyone);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) route_word(packet_word, last_word, last_word_bytes);
    end
    mismatches <= errs;
    awaiting   <= due_deliveries.size();
  end

endmodule

### test/testbench.sv
// Top of the SSRC demultiplexer testbench: clock, reset, register setup and
// packet stimulus, with the checker beside the block. Depends on rcsd_pkg,
// rtcp_compound_ssrc_demux_unit and rcsd_demux_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int WORD_TARGET = 1300;
  localparam int PHASES      = 6;
  localparam int SETTLE      = 8;
  localparam int IDLE_LIMIT  = 4000;

  localparam logic [7:0] PT_SDES = 8'd202;
  localparam logic [7:0] PT_APP  = 8'd204;
  localparam logic [7:0] PT_XR   = 8'd207;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rcsd_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_stall;
  logic [31:0]                 packet_word;
  logic                        last_word;
  logic [2:0]                  last_word_bytes;
  logic                        out_valid;
  logic                        out_stall;
  logic                        accepted;
  logic [3:0]                  deliver_mask;
  logic                        deliver_everyone;

  int          mismatches;
  int          awaiting;
  int          words_sent;
  int          burst_left;
  int          stall_style;
  int          stall_left;
  logic [31:0] cur_ssrc [4];
  logic [31:0] pkt[$];

  rtcp_compound_ssrc_demux_unit u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .packet_word, .last_word, .last_word_bytes,
    .out_valid, .out_stall, .accepted, .deliver_mask, .deliver_everyone
  );

  rcsd_demux_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .packet_word, .last_word, .last_word_bytes,
    .out_valid, .out_stall, .accepted, .deliver_mask, .deliver_everyone,
    .mismatches, .awaiting
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: runs of no stall, random stall and solid stall
  initial begin
    out_stall   = 1'b0;
    stall_left  = 0;
    stall_style = 0;
  end
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(1, 24);
    end
    stall_left--;
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] sub_header(input logic [4:0] cnt, input logic [7:0] pt,
                                             input logic [15:0] len);
    return {2'b10, 1'($urandom_range(0, 1)), cnt, pt, len};
  endfunction

  // mostly a registered SSRC, sometimes zero or anything
  function automatic logic [31:0] pick_ssrc();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return cur_ssrc[$urandom_range(0, 3)];
    if (r == 11) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4)  return rcsd_pkg::PT_SR;
    if (r < 8)  return rcsd_pkg::PT_RR;
    if (r < 11) return rcsd_pkg::PT_RTPFB;
    if (r < 14) return rcsd_pkg::PT_PSFB;
    if (r < 17) return rcsd_pkg::PT_BYE;
    if (r == 17) return ($urandom_range(0, 1) != 0) ? PT_SDES : PT_APP;
    if (r == 18) return PT_XR;
    return 8'($urandom);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the sender and wait until every delivery is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d,
                              input logic [3:0] en);
    drain();
    cur_ssrc[0] = a;
    cur_ssrc[1] = b;
    cur_ssrc[2] = c;
    cur_ssrc[3] = d;
    reg_write(rcsd_pkg::REG_SSRC_A, a);
    reg_write(rcsd_pkg::REG_SSRC_B, b);
    reg_write(rcsd_pkg::REG_SSRC_C, c);
    reg_write(rcsd_pkg::REG_SSRC_D, d);
    reg_write(rcsd_pkg::REG_ENABLE, {28'd0, en});
  endtask

  task automatic push_word(input logic [31:0] w, input logic last, input logic [2:0] nb);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    packet_word     <= w;
    last_word       <= last;
    last_word_bytes <= nb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_packet(input logic [2:0] tail_bytes);
    for (int i = 0; i < pkt.size(); i++) begin
      if (i == pkt.size() - 1) push_word(pkt[i], 1'b1, tail_bytes);
      else push_word(pkt[i], 1'b0, 3'($urandom_range(1, 4)));
    end
    pkt.delete();
  endtask

  task automatic add_sub(input logic [7:0] pt);
    logic [31:0] body[$];
    int          rc;
    int          nblk;
    int          len;
    int          r;
    rc   = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
    // large counts build only a few blocks, the rest lie past the length
    nblk = (rc > 3) ? $urandom_range(0, 3) : rc;
    case (pt)
      rcsd_pkg::PT_SR: begin
        body.push_back(pick_ssrc());
        repeat (5) body.push_back($urandom);
        repeat (nblk) begin
          body.push_back(pick_ssrc());
          repeat (5) body.push_back($urandom);
        end
      end
      rcsd_pkg::PT_RR: begin
        body.push_back(pick_ssrc());
        repeat (nblk) begin
          body.push_back(pick_ssrc());
          repeat (5) body.push_back($urandom);
        end
      end
      rcsd_pkg::PT_RTPFB, rcsd_pkg::PT_PSFB: begin
        body.push_back(pick_ssrc());
        body.push_back(($urandom_range(0, 3) == 0) ? 32'd0 : pick_ssrc());
        repeat ($urandom_range(0, 3)) body.push_back($urandom);
      end
      rcsd_pkg::PT_BYE: begin
        repeat (nblk) body.push_back(pick_ssrc());
      end
      default: begin
        repeat ($urandom_range(0, 4)) body.push_back($urandom);
      end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0 && body.size() > 0) begin
      len = $urandom_range(0, body.size() - 1);
      while (body.size() > len) void'(body.pop_back());
    end else if (r == 1) begin
      repeat ($urandom_range(1, 3)) body.push_back($urandom);
    end
    len = body.size();
    pkt.push_back(sub_header(5'(rc), pt, 16'(len)));
    foreach (body[i]) pkt.push_back(body[i]);
  endtask

  task automatic random_packet();
    int          r;
    int          keep;
    logic [31:0] head;
    logic [2:0]  tail;
    r    = $urandom_range(0, 99);
    tail = 3'd4;
    if (r < 78) begin
      repeat ($urandom_range(1, 4)) add_sub(pick_type());
      // cut the compound short now and then
      if ($urandom_range(0, 4) == 0 && pkt.size() > 1) begin
        keep = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > keep) void'(pkt.pop_back());
      end
      if ($urandom_range(0, 6) == 0) tail = 3'($urandom_range(1, 3));
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) pkt.push_back($urandom);
      tail = 3'($urandom_range(1, 4));
    end else begin
      add_sub(pick_type());
      head = pkt[0];
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 2))
          0:       head[31:30] = 2'd0;
          1:       head[31:30] = 2'd1;
          default: head[31:30] = 2'd3;
        endcase
      end else begin
        head[22:16] = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 63))
                                                  : 7'($urandom_range(96, 127));
      end
      pkt[0] = head;
    end
    send_packet(tail);
  endtask

  initial begin
    int          phase_end;
    logic [31:0] twin;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    packet_word     = '0;
    last_word       = 1'b0;
    last_word_bytes = 3'd4;
    words_sent      = 0;
    burst_left      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_config($urandom, $urandom, $urandom, $urandom, 4'hF);

    // a lone partial word is no packet at all
    pkt.push_back(sub_header(5'd0, rcsd_pkg::PT_RR, 16'd0));
    send_packet(3'd2);
    // receiver report block hits slot one, BYE hits slot three, the RR sender is not looked at
    pkt.push_back(sub_header(5'd1, rcsd_pkg::PT_RR, 16'd7));
    pkt.push_back(cur_ssrc[0]);
    pkt.push_back(cur_ssrc[1]);
    repeat (5) pkt.push_back($urandom);
    pkt.push_back(sub_header(5'd1, rcsd_pkg::PT_BYE, 16'd1));
    pkt.push_back(cur_ssrc[3]);
    send_packet(3'd4);
    // feedback with a zero media source floods
    pkt.push_back(sub_header(5'd1, rcsd_pkg::PT_PSFB, 16'd2));
    pkt.push_back(cur_ssrc[2]);
    pkt.push_back(32'd0);
    send_packet(3'd4);
    // wrong version
    pkt.push_back({2'b01, 1'b0, 5'd0, rcsd_pkg::PT_RR, 16'd1});
    pkt.push_back(cur_ssrc[0]);
    send_packet(3'd4);
    // sub-packet cut off by the packet end
    pkt.push_back(sub_header(5'd0, rcsd_pkg::PT_SR, 16'hFFFF));
    pkt.push_back(cur_ssrc[0]);
    send_packet(3'd4);
    // extended report floods, then an all-ones word
    pkt.push_back(sub_header(5'd0, PT_XR, 16'd0));
    send_packet(3'd4);
    pkt.push_back(32'hFFFF_FFFF);
    send_packet(3'd4);

    for (int phase = 0; phase < PHASES; phase++) begin
      twin = $urandom;
      case (phase)
        0: ;
        1: apply_config(32'd0, 32'd0, 32'd0, 32'd0, 4'hF);
        2: apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b0101);
        3: apply_config(twin, twin, $urandom, twin, 4'b1011);
        4: apply_config($urandom, $urandom, $urandom, $urandom, 4'h0);
        default: apply_config($urandom, $urandom, $urandom, $urandom,
                              4'($urandom_range(1, 15)));
      endcase
      phase_end = words_sent + WORD_TARGET / PHASES;
      while (words_sent < phase_end) random_packet();
    end

    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### rtcp_compound_ssrc_demux_unit.f
src/rcsd_pkg.sv
src/rcsd_cfg_regs.sv
src/rcsd_in_stage.sv
src/rcsd_parser.sv
src/rtcp_compound_ssrc_demux_unit.sv
src/rcsd_checker.sv
test/rcsd_demux_checker.sv
test/testbench.sv
